// ===== design/awlr_pkg.sv =====
// awlr_pkg: shared types and constants of the area-weighted line rebinning block
// no dependencies; imported by every module of the block
package awlr_pkg;

    localparam int CFG_W = 11;   // size register width
    localparam int IDX_W = 10;   // sample position / bin number
    localparam int SMP_W = 16;   // stored sample
    localparam int VAL_W = 34;   // bin value, eight fraction bits
    localparam int POS_W = 22;   // position on the common integer axis
    localparam int ACC_W = 28;   // overlap-weighted sum
    localparam int NUM_W = 36;   // dividend of the serial divider
    localparam int CNT_W = 6;    // divider step counter

    localparam logic REG_INPUT_SIZE  = 1'b0;
    localparam logic REG_OUTPUT_SIZE = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_BIN,
        KIND_OOR
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         index;
        logic signed [SMP_W-1:0]  sample;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULB,
        ST_D1GO,
        ST_D1WAIT,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_D2GO,
        ST_D2WAIT
    } t_state;

endpackage

// ===== design/awlr_div.sv =====
// awlr_div: restoring unsigned divider, one quotient bit per cycle
// depends on awlr_pkg
module awlr_div
    import awlr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [CFG_W-1:0]  i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo,
    output logic [CFG_W-1:0]  o_rem
);

    logic [NUM_W-1:0] r_quo;
    logic [CFG_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CFG_W:0]   w_trial;
    logic             w_fit;
    logic [CFG_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, i_den});
        w_diff  = w_trial - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[NUM_W-2:0], w_fit};
                r_rem <= w_fit ? w_diff[CFG_W-1:0] : w_trial[CFG_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== design/awlr_front.sv =====
// awlr_front: takes commands, classifies them and queues them for the back end
// depends on awlr_pkg
module awlr_front
    import awlr_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_operation,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [SMP_W-1:0]  i_sample,
    input  logic [CFG_W-1:0]         i_osz,
    input  logic                     i_pop,
    output logic                     o_busy,
    output t_qhead                   o_head
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    logic       w_keep;
    t_item      w_item;

    always_comb begin
        w_item.index  = i_index;
        w_item.sample = i_sample;
        w_keep        = 1'b1;
        if (!i_operation) begin
            w_item.kind = KIND_LOAD;
            // loads past the store are dropped here
            w_keep      = ({22'b0, i_index} < MAX_SAMPLES);
        end else if ({1'b0, i_index} >= i_osz) begin
            w_item.kind = KIND_OOR;
        end else begin
            w_item.kind = KIND_BIN;
        end
        o_busy = (r_cnt == 2'd2);
        w_push = i_start && !o_busy && w_keep;
        w_pop  = i_pop && (r_cnt != 2'd0);
        o_head.valid = (r_cnt != 2'd0);
        o_head.item  = r_q[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/awlr_back.sv =====
// awlr_back: sample store and bin engine, walks overlapping samples then divides
// depends on awlr_pkg and awlr_div
module awlr_back
    import awlr_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_qhead                   i_head,
    input  logic [CFG_W-1:0]         i_isz,
    input  logic [CFG_W-1:0]         i_osz,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [IDX_W-1:0]         o_bin_number,
    output logic signed [VAL_W-1:0]  o_bin_value,
    output logic                     o_out_of_range
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic signed [SMP_W-1:0] r_mem [MAX_SAMPLES];
    logic signed [SMP_W-1:0] r_rdata;

    t_state r_state, n_state;

    logic [IDX_W-1:0]          r_idx;
    logic [POS_W-1:0]          r_blo;
    logic [POS_W-1:0]          r_bhi;
    logic [POS_W-1:0]          r_cur;
    logic [POS_W-1:0]          r_seg;
    logic [CFG_W-1:0]          r_j;
    logic [CFG_W-1:0]          r_len;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic                      r_valid;
    logic [IDX_W-1:0]          r_bin;
    logic signed [VAL_W-1:0]   r_val;
    logic                      r_oor;

    logic                      w_we;
    logic                      w_dstart;
    logic [NUM_W-1:0]          w_dnum;
    logic                      w_ddone;
    logic [NUM_W-1:0]          w_dquo;
    logic [CFG_W-1:0]          w_drem;
    logic [POS_W-1:0]          w_hi;
    logic [ACC_W-1:0]          w_mag;
    logic [NUM_W-1:0]          w_sq;

    awlr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (i_osz),
        .o_done  (w_ddone),
        .o_quo   (w_dquo),
        .o_rem   (w_drem)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[AW'(i_head.item.index)] <= i_head.item.sample;
        end
        r_rdata <= r_mem[AW'(r_j)];
    end

    always_comb begin
        w_hi  = (r_bhi < r_seg) ? r_bhi : r_seg;
        w_mag = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
        w_sq  = r_neg ? (~w_dquo + 1'b1) : w_dquo;
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_dstart = 1'b0;
        w_dnum   = NUM_W'(r_blo);
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    case (i_head.item.kind)
                        KIND_LOAD: w_we = 1'b1;
                        KIND_BIN:  n_state = ST_MULB;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MULB: n_state = ST_D1GO;
            ST_D1GO: begin
                w_dstart = 1'b1;
                n_state  = ST_D1WAIT;
            end
            ST_D1WAIT: begin
                if (w_ddone) begin
                    n_state = ST_RD;
                end
            end
            ST_RD:  n_state = ST_MUL;
            ST_MUL: n_state = ST_ACC;
            ST_ACC: n_state = (r_cur == r_bhi) ? ST_D2GO : ST_RD;
            ST_D2GO: begin
                w_dstart = 1'b1;
                w_dnum   = {NUM_W'(w_mag)} << 8;
                n_state  = ST_D2WAIT;
            end
            ST_D2WAIT: begin
                if (w_ddone) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (r_state == ST_IDLE && i_head.valid && i_head.item.kind == KIND_OOR) begin
                r_valid <= 1'b1;
            end
            if (r_state == ST_D2WAIT && w_ddone) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_idx <= i_head.item.index;
                r_bin <= i_head.item.index;
                r_val <= '0;
                r_oor <= 1'b1;
            end
            ST_MULB: begin
                r_blo <= POS_W'(r_idx) * POS_W'(i_isz);
                r_acc <= '0;
            end
            ST_D1WAIT: begin
                r_j   <= w_dquo[CFG_W-1:0];
                r_cur <= r_blo;
                r_bhi <= r_blo + POS_W'(i_isz);
                r_seg <= r_blo - POS_W'(w_drem) + POS_W'(i_osz);
            end
            ST_RD: begin
                r_len <= CFG_W'(w_hi - r_cur);
                r_cur <= w_hi;
            end
            ST_MUL: begin
                r_prod <= ACC_W'($signed({1'b0, r_len}) * r_rdata);
            end
            ST_ACC: begin
                r_acc <= r_acc + r_prod;
                r_j   <= r_j + 1'b1;
                r_seg <= r_seg + POS_W'(i_osz);
            end
            ST_D2GO: begin
                r_neg <= r_acc[ACC_W-1];
            end
            ST_D2WAIT: begin
                r_val <= $signed(w_sq[VAL_W-1:0]);
                r_bin <= r_idx;
                r_oor <= 1'b0;
            end
            default: r_len <= r_len;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_bin_number   = r_bin;
    assign o_bin_value    = r_val;
    assign o_out_of_range = r_oor;

endmodule

// ===== design/area_weighted_line_rebin.sv =====
// Area-weighted line rebinning. A load command is written to the store as the back end pops it;
// a bin command makes two passes of the one-bit-per-cycle serial divider (first
// sample, final scaling) around a walk over the stored samples the bin overlaps
// (about input_size/output_size + 1 of them), with a store read, a multiply and an
// accumulate for each sample.
// A two-entry queue sits in front; busy rises only while it is full. Each
// result appears for one cycle on o_valid and cannot be held off.
// depends on awlr_pkg, awlr_front, awlr_back
module area_weighted_line_rebin
    import awlr_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_BINS    = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_operation,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [SMP_W-1:0]  i_sample,
    output logic                     o_valid,
    output logic [IDX_W-1:0]         o_bin_number,
    output logic signed [VAL_W-1:0]  o_bin_value,
    output logic                     o_out_of_range,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [CFG_W-1:0] r_input_size;
    logic [CFG_W-1:0] r_output_size;
    logic [CFG_W-1:0] w_isz;
    logic [CFG_W-1:0] w_osz;
    logic             w_pop;
    t_qhead           w_head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_size  <= CFG_W'(1024);
            r_output_size <= CFG_W'(1024);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_INPUT_SIZE) begin
                r_input_size <= pwdata[CFG_W-1:0];
            end else begin
                r_output_size <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = (paddr[2] == REG_OUTPUT_SIZE) ? 32'(r_output_size) : 32'(r_input_size);
        if (r_input_size == '0) begin
            w_isz = CFG_W'(1);
        end else if (32'(r_input_size) > MAX_SAMPLES) begin
            w_isz = CFG_W'(MAX_SAMPLES);
        end else begin
            w_isz = r_input_size;
        end
        if (r_output_size == '0) begin
            w_osz = CFG_W'(1);
        end else if (32'(r_output_size) > MAX_BINS) begin
            w_osz = CFG_W'(MAX_BINS);
        end else begin
            w_osz = r_output_size;
        end
    end

    awlr_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_index     (i_index),
        .i_sample    (i_sample),
        .i_osz       (w_osz),
        .i_pop       (w_pop),
        .o_busy      (busy),
        .o_head      (w_head)
    );

    awlr_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_isz          (w_isz),
        .i_osz          (w_osz),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .o_bin_number   (o_bin_number),
        .o_bin_value    (o_bin_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for area_weighted_line_rebin
// predicts each bin from its own copy of the sample store and size registers
// depends on awlr_pkg and the design files
`timescale 1ns / 100ps

module tb;
    import awlr_pkg::*;

    localparam int NSMP = 1024;
    localparam int NBIN = 1024;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [IDX_W-1:0]        bin_number;
        logic signed [VAL_W-1:0] bin_value;
        logic                    out_of_range;
    } t_bin_result;

    class rebin_scoreboard;
        logic signed [SMP_W-1:0] samples[NSMP];
        int unsigned in_size = 1024;
        int unsigned out_size = 1024;
        t_bin_result pending_bins[$];
        int unsigned mismatches = 0;

        function int unsigned clamp(int unsigned r, int unsigned lim);
            if (r == 0) return 1;
            if (r > lim) return lim;
            return r;
        endfunction

        function longint weighted_bin(int unsigned bin);
            longint isz, osz, b_lo, b_hi, j0, j1, lo, hi, acc;
            isz = clamp(in_size, NSMP);
            osz = clamp(out_size, NBIN);
            b_lo = bin * isz;
            b_hi = b_lo + isz;
            j0 = b_lo / osz;
            j1 = b_hi / osz;
            acc = 0;
            for (longint j = j0; j <= j1 && j < isz; j++) begin
                lo = (b_lo > j * osz) ? b_lo : j * osz;
                hi = (b_hi < (j + 1) * osz) ? b_hi : (j + 1) * osz;
                if (hi > lo) acc += (hi - lo) * longint'(samples[j]);
            end
            return (acc * 256) / osz;
        endfunction

        function void note_item(logic op, logic [IDX_W-1:0] idx, logic signed [SMP_W-1:0] smp);
            t_bin_result r;
            if (op == 1'b0) begin
                samples[idx] = smp;
                return;
            end
            r.bin_number = idx;
            if (idx >= clamp(out_size, NBIN)) begin
                r.bin_value = '0;
                r.out_of_range = 1'b1;
            end else begin
                r.bin_value = VAL_W'(weighted_bin(idx));
                r.out_of_range = 1'b0;
            end
            pending_bins.push_back(r);
        endfunction

        function void check_result(logic [IDX_W-1:0] bn, logic signed [VAL_W-1:0] val,
                                   logic oor);
            t_bin_result e;
            if (pending_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bin %0d value %0d oor %0b", bn, val, oor);
                return;
            end
            e = pending_bins.pop_front();
            if (bn !== e.bin_number || val !== e.bin_value || oor !== e.out_of_range) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected bin %0d value %0d oor %0b, got %0d %0d %0b",
                             e.bin_number, e.bin_value, e.out_of_range, bn, val, oor);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_operation = 1'b0;
    logic [IDX_W-1:0]        i_index = '0;
    logic signed [SMP_W-1:0] i_sample = '0;
    logic                    o_valid;
    logic [IDX_W-1:0]        o_bin_number;
    logic signed [VAL_W-1:0] o_bin_value;
    logic                    o_out_of_range;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [2:0]              paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    rebin_scoreboard sb = new();
    bit     written[NSMP];
    bit     no_gaps = 0;
    longint cycle_count = 0;

    area_weighted_line_rebin DUT (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // results hold for exactly one cycle, stable at the falling edge
    always @(negedge i_clk)
        if (i_rst_n && o_valid) sb.check_result(o_bin_number, o_bin_value, o_out_of_range);

    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom % 100;
        if (no_gaps || r < 40) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function logic signed [SMP_W-1:0] pick_sample();
        case ($urandom % 4)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send(logic op, logic [IDX_W-1:0] idx, logic signed [SMP_W-1:0] smp);
        bit taken;
        int unsigned gap;
        start <= 1'b1;
        i_operation <= op;
        i_index <= idx;
        i_sample <= smp;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        sb.note_item(op, idx, smp);
        if (op == 1'b0) written[idx] = 1'b1;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // loads any sample the bin overlaps that was never written, then asks for the bin
    task automatic request_bin(logic [IDX_W-1:0] bin);
        longint isz, osz, j0, j1;
        isz = sb.clamp(sb.in_size, NSMP);
        osz = sb.clamp(sb.out_size, NBIN);
        if (bin < osz) begin
            j0 = (bin * isz) / osz;
            j1 = ((bin + 1) * isz) / osz;
            for (longint j = j0; j <= j1 && j < isz; j++)
                if (!written[j]) send(1'b0, IDX_W'(j), pick_sample());
        end
        send(1'b1, bin, '0);
    endtask

    task automatic write_size(logic reg_sel, logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (sb.pending_bins.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= (reg_sel == REG_OUTPUT_SIZE) ? 3'd4 : 3'd0;
        pwdata <= {$urandom} & ~32'h7ff | 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_OUTPUT_SIZE) sb.out_size = value;
        else sb.in_size = value;
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] isz, logic [CFG_W-1:0] osz);
        write_size(REG_INPUT_SIZE, isz);
        write_size(REG_OUTPUT_SIZE, osz);
    endtask

    task automatic random_phase(int unsigned n_items);
        int unsigned osz, ratio, bins_left;
        osz = sb.clamp(sb.out_size, NBIN);
        ratio = sb.clamp(sb.in_size, NSMP) / osz;
        bins_left = 30000 / (3 * ratio + 90);
        no_gaps = ($urandom % 4 == 0);
        for (int unsigned k = 0; k < n_items; k++) begin
            if ($urandom % 10 < 3 || bins_left == 0)
                send(1'b0, IDX_W'($urandom), pick_sample());
            else begin
                bins_left--;
                if ($urandom % 10 == 0) request_bin(IDX_W'($urandom));
                else request_bin(IDX_W'($urandom_range(osz - 1, 0)));
            end
        end
        no_gaps = 0;
    endtask

    initial begin
        logic [CFG_W-1:0] isz, osz;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners of the sizes, of the samples and of the bin range
        set_sizes(11'd1024, 11'd1024);
        send(1'b0, 10'd0, 16'sh7fff);
        send(1'b0, 10'd1023, 16'sh8000);
        request_bin(10'd0);
        request_bin(10'd1023);
        set_sizes(11'd1, 11'd1);
        request_bin(10'd0);
        request_bin(10'd1);
        request_bin(10'd1023);
        set_sizes(11'd0, 11'd0);
        request_bin(10'd0);
        request_bin(10'd5);
        set_sizes(11'd2047, 11'd2047);
        request_bin(10'd1023);
        set_sizes(11'd1, 11'd1024);
        request_bin(10'd0);
        request_bin(10'd1023);
        // whole line into one bin, all at the most negative sample
        for (int j = 0; j < NSMP; j++) begin
            sb.samples[j] = sb.samples[j];
            if (j < 8) send(1'b0, IDX_W'(j), 16'sh8000);
        end
        set_sizes(11'd8, 11'd1);
        request_bin(10'd0);
        request_bin(10'd1);

        random_phase(120);
        set_sizes(11'd1024, 11'd1);
        random_phase(40);
        set_sizes(11'd1024, 11'd1024);
        random_phase(200);
        set_sizes(11'd7, 11'd3);
        random_phase(150);
        set_sizes(11'd3, 11'd1000);
        random_phase(150);
        for (int p = 0; p < 6; p++) begin
            isz = CFG_W'($urandom);
            osz = CFG_W'($urandom);
            if ($urandom % 2) isz = CFG_W'($urandom_range(64, 1));
            set_sizes(isz, osz);
            random_phase(130);
        end

        start <= 1'b0;
        while (sb.pending_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_bins.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
